// ===== rtl/dst_pkg.sv =====
// ---------------------------------------------------------------------------
// dst_pkg: shared types and constants of the source tokenizer
// Token kinds, scan modes, the keyword table and the token record.
// ---------------------------------------------------------------------------
package dst_pkg;

    localparam int KW_COUNT = 58;
    localparam int KW_SPAN  = 16;

    // Operator token kinds.
    localparam logic [6:0] K_LPAREN   = 7'd0;
    localparam logic [6:0] K_RPAREN   = 7'd1;
    localparam logic [6:0] K_LBRACE   = 7'd2;
    localparam logic [6:0] K_RBRACE   = 7'd3;
    localparam logic [6:0] K_LBRACKET = 7'd4;
    localparam logic [6:0] K_RBRACKET = 7'd5;
    localparam logic [6:0] K_COMMA    = 7'd6;
    localparam logic [6:0] K_DOT      = 7'd7;
    localparam logic [6:0] K_SEMI     = 7'd8;
    localparam logic [6:0] K_PLUS     = 7'd9;
    localparam logic [6:0] K_MINUS    = 7'd10;
    localparam logic [6:0] K_ARROW    = 7'd11;
    localparam logic [6:0] K_STAR     = 7'd12;
    localparam logic [6:0] K_SLASH    = 7'd13;
    localparam logic [6:0] K_PERCENT  = 7'd14;
    localparam logic [6:0] K_AT       = 7'd15;
    localparam logic [6:0] K_BANG     = 7'd16;
    localparam logic [6:0] K_NE       = 7'd17;
    localparam logic [6:0] K_ASSIGN   = 7'd18;
    localparam logic [6:0] K_EQ       = 7'd19;
    localparam logic [6:0] K_LT       = 7'd20;
    localparam logic [6:0] K_LE       = 7'd21;
    localparam logic [6:0] K_GT       = 7'd22;
    localparam logic [6:0] K_GE       = 7'd23;
    localparam logic [6:0] K_AND      = 7'd24;
    localparam logic [6:0] K_OR       = 7'd25;
    localparam logic [6:0] K_COLON    = 7'd26;
    localparam logic [6:0] K_SCOPE    = 7'd27;

    localparam logic [6:0] K_IDENT   = 7'd28;
    localparam logic [6:0] K_NUMBER  = 7'd29;
    localparam logic [6:0] K_STRING  = 7'd30;
    localparam logic [6:0] K_NEWLINE = 7'd31;
    localparam logic [6:0] K_EOF     = 7'd32;
    localparam logic [6:0] K_ERROR   = 7'd33;
    localparam logic [6:0] K_KW0     = 7'd34;
    localparam logic [6:0] K_NONE    = 7'd127;

    // Error codes carried by error tokens.
    localparam logic E_UNTERMINATED = 1'b0;
    localparam logic E_UNEXPECTED   = 1'b1;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_STRING,
        M_SLASH, M_LINE, M_BLOCK, M_BLOCK_STAR,
        M_H_MINUS, M_H_BANG, M_H_EQ, M_H_LT, M_H_GT, M_H_AMP, M_H_BAR, M_H_COLON
    } t_mode;

    // One emitted token.
    typedef struct packed {
        logic [6:0]         kind;
        logic               code;
        logic [15:0]        start;
        logic [15:0]        len;
        logic [15:0]        line;
        logic signed [16:0] col;
    } t_token;

    // Keyword table, right-aligned as string literals are, zero padded to
    // 16 bytes; the last character sits in the lowest byte.
    function automatic logic [8*KW_SPAN-1:0] kw_word(input int i);
        logic [8*KW_SPAN-1:0] w;
        w = '0;
        unique case (i)
            0: w = "robot"; 1: w = "motor"; 2: w = "servo"; 3: w = "sensor";
            4: w = "gpio"; 5: w = "bus"; 6: w = "net"; 7: w = "mqtt";
            8: w = "topic"; 9: w = "publish"; 10: w = "on"; 11: w = "task";
            12: w = "schedule"; 13: w = "limits"; 14: w = "when"; 15: w = "if";
            16: w = "else"; 17: w = "let"; 18: w = "wait"; 19: w = "stop";
            20: w = "turn"; 21: w = "estop"; 22: w = "message"; 23: w = "as";
            24: w = "type"; 25: w = "mode"; 26: w = "broker"; 27: w = {"client_", "id"};
            28: w = "qos"; 29: w = "priority"; 30: w = "max"; 31: w = "min";
            32: w = "json"; 33: w = "now"; 34: w = "value"; 35: w = "power";
            36: w = "reads"; 37: w = "clockwise"; 38: w = "counterclockwise";
            39: w = "Percent"; 40: w = "ms"; 41: w = "cm"; 42: w = "deg";
            43: w = "Hz"; 44: w = "Distance"; 45: w = "Angle"; 46: w = "Speed";
            47: w = "HIGH"; 48: w = "MEDIUM"; 49: w = "LOW"; 50: w = "Input";
            51: w = "Output"; 52: w = "InputPullup"; 53: w = "InputPulldown";
            54: w = "I2C"; 55: w = "SPI"; 56: w = "CAN"; 57: w = "UART";
            default: w = '0;
        endcase
        return w;
    endfunction

    // Length of a keyword: one above its highest non-zero byte.
    function automatic logic [4:0] kw_len(input int i);
        logic [8*KW_SPAN-1:0] w;
        logic [4:0]           n;
        w = kw_word(i);
        n = '0;
        for (int b = 0; b < KW_SPAN; b++) begin
            if (w[8*b +: 8] != 8'd0) n = 5'(b + 1);
        end
        return n;
    endfunction

endpackage

// ===== rtl/dst_kw_match.sv =====
// ---------------------------------------------------------------------------
// dst_kw_match: keyword lookup
// Compares the collected word against every keyword in parallel.
// ---------------------------------------------------------------------------
module dst_kw_match
    import dst_pkg::*;
#(
    parameter int WORD_MAX = 16
) (
    input  logic [8*WORD_MAX-1:0] i_word,
    input  logic [5:0]            i_count,
    output logic [6:0]            o_kind
);

    // Word byte b sits at i_word[8*b +: 8]; each keyword is shifted up so
    // that its first byte sits at the top end.
    always_comb begin
        logic hit;
        logic [4:0] klen;
        logic [8*KW_SPAN-1:0] kw;
        o_kind = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            klen = kw_len(i);
            kw   = kw_word(i) << (8 * (KW_SPAN - int'(klen)));
            hit  = (i_count == {1'b0, klen});
            for (int b = 0; b < KW_SPAN; b++) begin
                if (b < int'(klen) && i_word[8*b +: 8] != kw[8*(KW_SPAN-1-b) +: 8])
                    hit = 1'b0;
            end
            if (hit) o_kind = 7'(int'(K_KW0) + i);
        end
    end

endmodule

// ===== rtl/dst_scan_core.sv =====
// ---------------------------------------------------------------------------
// dst_scan_core: scanner state and token formation
// Takes one byte and produces up to three tokens for the result buffer.
// ---------------------------------------------------------------------------
module dst_scan_core
    import dst_pkg::*;
#(
    parameter int TEXT_BYTES = 65536,
    parameter int WORD_MAX   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  logic [7:0] i_ch,
    output t_token    o_tok [3],
    output logic [1:0] o_cnt
);

    localparam int OW = (TEXT_BYTES > 1) ? $clog2(TEXT_BYTES) : 1;
    localparam int WB = $clog2(WORD_MAX);

    t_mode                r_mode, n_mode;
    logic [7:0]           r_word [WORD_MAX];
    logic [5:0]           r_wcnt, n_wcnt;
    logic [OW-1:0]        r_off, n_off;
    logic [OW-1:0]        r_beg, n_beg;
    logic [15:0]          r_line, n_line;
    logic [15:0]          r_col, n_col;
    logic [15:0]          r_rlen, n_rlen;
    logic                 n_wwe;
    logic [8*WORD_MAX-1:0] w_word;
    logic [6:0]           w_kwkind;

    // Flatten the word store for the keyword compare.
    always_comb begin
        for (int b = 0; b < WORD_MAX; b++) w_word[8*b +: 8] = r_word[b];
    end

    dst_kw_match #(.WORD_MAX(WORD_MAX)) u_kw (
        .i_word (w_word),
        .i_count(r_wcnt),
        .o_kind (w_kwkind)
    );

    // The text offset wraps at the text size.
    function automatic logic [OW-1:0] off_inc(input logic [OW-1:0] v);
        return (v == OW'(TEXT_BYTES - 1)) ? '0 : v + 1'b1;
    endfunction
    function automatic logic [OW-1:0] off_dec(input logic [OW-1:0] v);
        return (v == '0) ? OW'(TEXT_BYTES - 1) : v - 1'b1;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic [6:0] single_kind(input logic [7:0] c);
        unique case (c)
            "(": return K_LPAREN;   ")": return K_RPAREN;   "{": return K_LBRACE;
            "}": return K_RBRACE;   "[": return K_LBRACKET; "]": return K_RBRACKET;
            ",": return K_COMMA;    ".": return K_DOT;      ";": return K_SEMI;
            "+": return K_PLUS;     "*": return K_STAR;     "%": return K_PERCENT;
            "@": return K_AT;
            default: return K_NONE;
        endcase
    endfunction

    // Next-state and token logic for one byte.
    always_comb begin
        t_token     tk [3];
        logic [1:0] n;
        logic       again;
        logic [7:0] c;
        logic [7:0] sec;
        logic [6:0] pk, sk;
        logic [16:0] sum;
        c = i_ch;
        n = '0;
        again = 1'b0;
        sum = '0;
        sec = 8'd0; pk = K_NONE; sk = K_NONE;
        n_mode = r_mode; n_wcnt = r_wcnt; n_off = r_off; n_beg = r_beg;
        n_line = r_line; n_col = r_col; n_rlen = r_rlen; n_wwe = 1'b0;
        for (int i = 0; i < 3; i++) tk[i] = '0;

        unique case (r_mode)
            M_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    if (r_wcnt < 6'(WORD_MAX)) begin
                        n_wwe = 1'b1; n_wcnt = r_wcnt + 6'd1;
                    end else n_wcnt = 6'(WORD_MAX + 1);
                    n_rlen = (r_rlen == SAT16) ? SAT16 : r_rlen + 16'd1;
                    n_off = off_inc(r_off);
                    if (r_col != SAT16) n_col = r_col + 16'd1;
                end else begin
                    tk[n] = '{w_kwkind, 1'b0, 16'(r_beg), r_rlen, r_line,
                              $signed({1'b0, r_col}) - $signed({1'b0, r_rlen})};
                    n = n + 2'd1; again = 1'b1;
                end
            end
            M_NUM_INT, M_NUM_FRAC: begin
                if (is_digit(c)) begin
                    n_rlen = (r_rlen == SAT16) ? SAT16 : r_rlen + 16'd1;
                    n_off = off_inc(r_off);
                    if (r_col != SAT16) n_col = r_col + 16'd1;
                end else if (c == "." && r_mode == M_NUM_INT) begin
                    n_off = off_inc(r_off);
                    if (r_col != SAT16) n_col = r_col + 16'd1;
                    n_mode = M_NUM_DOT;
                end else begin
                    tk[n] = '{K_NUMBER, 1'b0, 16'(r_beg), r_rlen, r_line,
                              $signed({1'b0, r_col}) - $signed({1'b0, r_rlen})};
                    n = n + 2'd1; again = 1'b1;
                end
            end
            M_NUM_DOT: begin
                if (is_digit(c)) begin
                    sum = {1'b0, r_rlen} + 17'd2;
                    n_rlen = sum[16] ? SAT16 : sum[15:0];
                    n_off = off_inc(r_off);
                    if (r_col != SAT16) n_col = r_col + 16'd1;
                    n_mode = M_NUM_FRAC;
                end else begin
                    tk[0] = '{K_NUMBER, 1'b0, 16'(r_beg), r_rlen, r_line,
                              $signed({1'b0, r_col}) - 17'sd1 - $signed({1'b0, r_rlen})};
                    tk[1] = '{K_DOT, 1'b0, 16'(off_dec(r_off)), 16'd1, r_line,
                              $signed({1'b0, r_col}) - 17'sd1};
                    n = 2'd2; again = 1'b1;
                end
            end
            M_STRING: begin
                if (c == "\"") begin
                    sum = {1'b0, r_rlen} + 17'd1;
                    n_rlen = sum[16] ? SAT16 : sum[15:0];
                    n_off = off_inc(r_off);
                    n_col = (r_col != SAT16) ? r_col + 16'd1 : r_col;
                    tk[0] = '{K_STRING, 1'b0, 16'(r_beg), n_rlen, r_line,
                              $signed({1'b0, n_col}) - $signed({1'b0, n_rlen})};
                    n = 2'd1; n_mode = M_IDLE;
                end else if (c == 8'd0) begin
                    tk[0] = '{K_ERROR, E_UNTERMINATED, 16'(r_beg), 16'd19, r_line,
                              $signed({1'b0, r_col})};
                    n = 2'd1; again = 1'b1;
                end else begin
                    n_rlen = (r_rlen == SAT16) ? SAT16 : r_rlen + 16'd1;
                    n_off = off_inc(r_off);
                    if (c == "\n") begin
                        if (r_line != SAT16) n_line = r_line + 16'd1;
                        n_col = 16'd1;
                    end else if (r_col != SAT16) n_col = r_col + 16'd1;
                end
            end
            M_SLASH: begin
                if (c == "/" || c == "*") begin
                    n_off = off_inc(r_off);
                    if (r_col != SAT16) n_col = r_col + 16'd1;
                    n_mode = (c == "/") ? M_LINE : M_BLOCK;
                end else begin
                    tk[0] = '{K_SLASH, 1'b0, 16'(r_beg), 16'd1, r_line,
                              $signed({1'b0, r_col}) - 17'sd1};
                    n = 2'd1; again = 1'b1;
                end
            end
            M_LINE: begin
                if (c == "\n" || c == 8'd0) again = 1'b1;
                else begin
                    n_off = off_inc(r_off);
                    if (r_col != SAT16) n_col = r_col + 16'd1;
                end
            end
            M_BLOCK, M_BLOCK_STAR: begin
                if (c == 8'd0) again = 1'b1;
                else begin
                    n_off = off_inc(r_off);
                    if (r_col != SAT16) n_col = r_col + 16'd1;
                    if (c == "/" && r_mode == M_BLOCK_STAR) n_mode = M_IDLE;
                    else if (c == "*") n_mode = M_BLOCK_STAR;
                    else begin
                        if (c == "\n") begin
                            if (r_line != SAT16) n_line = r_line + 16'd1;
                            n_col = 16'd1;
                        end
                        n_mode = M_BLOCK;
                    end
                end
            end
            M_H_MINUS, M_H_BANG, M_H_EQ, M_H_LT, M_H_GT, M_H_AMP, M_H_BAR,
            M_H_COLON: begin
                unique case (r_mode)
                    M_H_MINUS: begin sec = ">"; pk = K_ARROW; sk = K_MINUS;  end
                    M_H_BANG:  begin sec = "="; pk = K_NE;    sk = K_BANG;   end
                    M_H_EQ:    begin sec = "="; pk = K_EQ;    sk = K_ASSIGN; end
                    M_H_LT:    begin sec = "="; pk = K_LE;    sk = K_LT;     end
                    M_H_GT:    begin sec = "="; pk = K_GE;    sk = K_GT;     end
                    M_H_AMP:   begin sec = "&"; pk = K_AND;   sk = K_NONE;   end
                    M_H_BAR:   begin sec = "|"; pk = K_OR;    sk = K_NONE;   end
                    default:   begin sec = ":"; pk = K_SCOPE; sk = K_COLON;  end
                endcase
                if (c == sec) begin
                    n_off = off_inc(r_off);
                    n_col = (r_col != SAT16) ? r_col + 16'd1 : r_col;
                    n_rlen = 16'd2;
                    tk[0] = '{pk, 1'b0, 16'(r_beg), 16'd2, r_line,
                              $signed({1'b0, n_col}) - 17'sd2};
                    n = 2'd1; n_mode = M_IDLE;
                end else begin
                    if (sk == K_NONE)
                        tk[0] = '{K_ERROR, E_UNEXPECTED, 16'(r_beg), 16'd20, r_line,
                                  $signed({1'b0, r_col})};
                    else
                        tk[0] = '{sk, 1'b0, 16'(r_beg), 16'd1, r_line,
                                  $signed({1'b0, r_col}) - 17'sd1};
                    n = 2'd1; again = 1'b1;
                end
            end
            default: again = 1'b1;
        endcase

        // Idle handling, also reached when the byte ended a held token.
        if (again) begin
            n_mode = M_IDLE;
            if (c == 8'd0) begin
                tk[n] = '{K_EOF, 1'b0, 16'(n_off), 16'd0, n_line,
                          $signed({1'b0, n_col})};
                n = n + 2'd1;
                n_off = '0; n_beg = '0; n_line = 16'd1; n_col = 16'd1;
                n_wcnt = '0; n_rlen = '0;
            end else if (c == " " || c == "\r" || c == "\t") begin
                n_off = off_inc(n_off);
                if (n_col != SAT16) n_col = n_col + 16'd1;
            end else begin
                n_beg = n_off; n_rlen = 16'd1; n_off = off_inc(n_off);
                if (n_col != SAT16) n_col = n_col + 16'd1;
                if (c == "\n") begin
                    if (n_line != SAT16) n_line = n_line + 16'd1;
                    n_col = 16'd1;
                    tk[n] = '{K_NEWLINE, 1'b0, 16'(n_beg), 16'd1, n_line, 17'sd0};
                    n = n + 2'd1;
                end else if (c == "/") n_mode = M_SLASH;
                else if (c == "\"") n_mode = M_STRING;
                else if (is_alpha(c) || c == "_") begin
                    n_wwe = 1'b1; n_wcnt = 6'd1; n_mode = M_IDENT;
                end else if (is_digit(c)) n_mode = M_NUM_INT;
                else if (single_kind(c) != K_NONE) begin
                    tk[n] = '{single_kind(c), 1'b0, 16'(n_beg), 16'd1, n_line,
                              $signed({1'b0, n_col}) - 17'sd1};
                    n = n + 2'd1;
                end else if (c == "-") n_mode = M_H_MINUS;
                else if (c == "!") n_mode = M_H_BANG;
                else if (c == "=") n_mode = M_H_EQ;
                else if (c == "<") n_mode = M_H_LT;
                else if (c == ">") n_mode = M_H_GT;
                else if (c == "&") n_mode = M_H_AMP;
                else if (c == "|") n_mode = M_H_BAR;
                else if (c == ":") n_mode = M_H_COLON;
                else begin
                    tk[n] = '{K_ERROR, E_UNEXPECTED, 16'(n_beg), 16'd20, n_line,
                              $signed({1'b0, n_col})};
                    n = n + 2'd1;
                end
            end
        end
        o_tok = tk;
        o_cnt = n;
    end

    // Scanner state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_wcnt <= '0; r_off <= '0; r_beg <= '0;
            r_line <= 16'd1; r_col <= 16'd1; r_rlen <= '0;
        end else if (i_take) begin
            r_mode <= n_mode; r_wcnt <= n_wcnt; r_off <= n_off; r_beg <= n_beg;
            r_line <= n_line; r_col <= n_col; r_rlen <= n_rlen;
        end
    end

    // Word store write; the slot is the new count less one.
    always_ff @(posedge i_clk) begin
        if (i_take && n_wwe) begin
            r_word[WB'(n_wcnt - 6'd1)] <= i_ch;
        end
    end

endmodule

// ===== rtl/dst_out_queue.sv =====
// ---------------------------------------------------------------------------
// dst_out_queue: result buffer
// Holds up to three tokens of one byte and hands them out one word at a time.
// ---------------------------------------------------------------------------
module dst_out_queue
    import dst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_token     i_tok [3],
    input  logic [1:0] i_cnt,
    input  logic       i_ready,
    output logic       o_valid,
    output logic       o_free,
    output t_token     o_tok,
    output logic       o_last
);

    t_token     r_tok [3];
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       w_pop;

    assign o_valid = (r_idx != r_cnt);
    assign w_pop   = o_valid && i_ready;
    // Free when empty or when the final word leaves this cycle.
    assign o_free  = !o_valid || (w_pop && r_idx + 2'd1 == r_cnt);
    assign o_tok   = r_tok[r_idx == 2'd3 ? 2'd0 : r_idx];
    assign o_last  = (r_idx + 2'd1 == r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt; r_idx <= '0;
        end else if (w_pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_tok <= i_tok;
    end

endmodule

// ===== rtl/dsl_source_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// dsl_source_tokenizer_unit: byte-stream tokenizer for the robot language
// Top level joining the scanner core and the result buffer.
// ---------------------------------------------------------------------------
// Usage:
//   Source bytes enter on i_ch with i_valid/o_ready; a byte of zero ends the
//   text and returns offset, line and column to their start values.
//   Tokens leave on o_* fields with o_valid/i_ready, one word per token;
//   o_last_of_run marks the final token caused by one byte.
// Tokens are registered in the result buffer; the first of a byte's tokens
//   shows in the cycle after the byte is taken. Throughput: one byte per
//   cycle while each byte gives at most one token and the receiver is ready;
//   more tokens hold the input until the single output port drains them.
// Reset: synchronous, active low; the scanner returns to idle, line and
//   column to one. When the receiver stalls, the buffer keeps its tokens
//   and o_ready drops until the last of them is taken.
// ---------------------------------------------------------------------------
module dsl_source_tokenizer_unit
    import dst_pkg::*;
#(
    parameter int TEXT_BYTES = 65536,
    parameter int WORD_MAX   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_ch,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [6:0]         o_token_kind,
    output logic               o_error_code,
    output logic [15:0]        o_start_offset,
    output logic [15:0]        o_token_length,
    output logic [15:0]        o_line_number,
    output logic signed [16:0] o_column_number,
    output logic               o_last_of_run
);

    t_token     w_tok [3];
    t_token     w_out;
    logic [1:0] w_cnt;
    logic       w_take;

    assign w_take = i_valid && o_ready;

    dst_scan_core #(.TEXT_BYTES(TEXT_BYTES), .WORD_MAX(WORD_MAX)) u_core (
        .i_clk (i_clk), .i_rst_n(i_rst_n), .i_take(w_take), .i_ch(i_ch),
        .o_tok (w_tok), .o_cnt(w_cnt)
    );

    dst_out_queue u_queue (
        .i_clk (i_clk), .i_rst_n(i_rst_n), .i_load(w_take), .i_tok(w_tok),
        .i_cnt (w_cnt), .i_ready(i_ready), .o_valid(o_valid), .o_free(o_ready),
        .o_tok (w_out), .o_last(o_last_of_run)
    );

    assign o_token_kind    = w_out.kind;
    assign o_error_code    = w_out.code;
    assign o_start_offset  = w_out.start;
    assign o_token_length  = w_out.len;
    assign o_line_number   = w_out.line;
    assign o_column_number = w_out.col;

endmodule

// ===== rtl/dst_checker.sv =====
// ---------------------------------------------------------------------------
// dst_checker: port-level checks of the tokenizer
// Watches the handshakes and token fields over time.
// ---------------------------------------------------------------------------
module dst_checker
    import dst_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [6:0] o_token_kind,
    input logic [15:0] o_line_number,
    input logic       o_last_of_run
);

    // A waiting input word stays offered until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid)
        else $error("input word withdrawn before acceptance");

    // A stalled output word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_kind))
        else $error("output word changed while stalled");

    // Input is refused while more than the final token waits.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> !o_ready)
        else $error("input taken while tokens pending");

    // The eof token always closes its run.
    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == K_EOF |-> o_last_of_run)
        else $error("eof token not last of run");

    // Line numbers never read zero.
    a_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_line_number != 16'd0)
        else $error("line number zero");

endmodule

bind dsl_source_tokenizer_unit dst_checker u_dst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_token_kind(o_token_kind),
    .o_line_number(o_line_number), .o_last_of_run(o_last_of_run)
);

// ===== tb/tb_dsl_source_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// tb_dsl_source_tokenizer_unit: self-checking bench for the source tokenizer
// Feeds source text byte by byte, predicts every token from a behavioural
// model of the scanner and compares each output word field by field.
// ---------------------------------------------------------------------------
module tb_dsl_source_tokenizer_unit;
    import dst_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_ch;
    logic               o_valid;
    logic               i_ready;
    logic [6:0]         o_token_kind;
    logic               o_error_code;
    logic [15:0]        o_start_offset;
    logic [15:0]        o_token_length;
    logic [15:0]        o_line_number;
    logic signed [16:0] o_column_number;
    logic               o_last_of_run;

    localparam int WORD_LIMIT = 16;

    // Expected token together with its end-of-run flag.
    typedef struct packed {
        t_token tok;
        logic   last;
    } t_expected_token;

    t_expected_token token_queue[$];
    int              error_count;
    int              token_count;
    int              byte_count;
    int              send_idle_pct;
    int              recv_idle_pct;

    // Scanner state held by the predictor.
    t_mode       scan_mode;
    logic [7:0]  word_buf[WORD_LIMIT];
    int          word_count;
    int unsigned text_offset;
    int unsigned token_begin;
    int unsigned line_count;
    int unsigned column_count;
    int unsigned run_len;
    int          step_tokens;

    dsl_source_tokenizer_unit uut (.*);

    always #4 i_clk = ~i_clk;

    // Pushes one predicted token.
    task automatic push_token(input logic [6:0] kind, input logic code,
                              input int unsigned start, input int unsigned len,
                              input int col);
        t_expected_token e;
        if (step_tokens >= 3) return;
        e.tok.kind  = kind;
        e.tok.code  = code;
        e.tok.start = start[15:0];
        e.tok.len   = (len > 65535) ? SAT16 : len[15:0];
        e.tok.line  = line_count[15:0];
        e.tok.col   = col[16:0];
        e.last      = 1'b0;
        token_queue.push_back(e);
        step_tokens++;
    endtask

    task automatic push_plain(input logic [6:0] kind, input int unsigned len);
        push_token(kind, 1'b0, token_begin, len, int'(column_count) - int'(len));
    endtask

    task automatic push_error(input logic code);
        push_token(K_ERROR, code, token_begin, code ? 20 : 19, int'(column_count));
    endtask

    task automatic step_over();
        text_offset = (text_offset + 1) % 65536;
        if (column_count < 65535) column_count++;
    endtask

    task automatic grow_len(input int unsigned n);
        run_len += n;
        if (run_len > 65535) run_len = 65535;
    endtask

    task automatic new_line();
        if (line_count < 65535) line_count++;
    endtask

    task automatic start_token();
        token_begin = text_offset;
        run_len = 1;
        step_over();
    endtask

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Resolves the held word against the keyword table; each entry is
    // shifted so that its first byte sits at the top end.
    function automatic logic [6:0] word_kind();
        logic [8*KW_SPAN-1:0] w;
        bit                   same;
        if (word_count == 0 || word_count > WORD_LIMIT) return K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            w = kw_word(i) << (8 * (KW_SPAN - int'(kw_len(i))));
            same = 1'b1;
            for (int b = 0; b < KW_SPAN; b++) begin
                if (b < word_count) begin
                    if (w[8*(KW_SPAN-1-b) +: 8] != word_buf[b]) same = 1'b0;
                end else if (w[8*(KW_SPAN-1-b) +: 8] != 8'd0) begin
                    same = 1'b0;
                end
            end
            if (same) return K_KW0 + 7'(i);
        end
        return K_IDENT;
    endfunction

    function automatic logic [6:0] single_op(input logic [7:0] c);
        case (c)
            "(": return K_LPAREN;   ")": return K_RPAREN;   "{": return K_LBRACE;
            "}": return K_RBRACE;   "[": return K_LBRACKET; "]": return K_RBRACKET;
            ",": return K_COMMA;    ".": return K_DOT;      ";": return K_SEMI;
            "+": return K_PLUS;     "*": return K_STAR;     "%": return K_PERCENT;
            "@": return K_AT;
            default: return K_NONE;
        endcase
    endfunction

    // Opening byte of a held operator, mapped to its hold mode.
    function automatic t_mode hold_mode(input logic [7:0] c);
        case (c)
            "-": return M_H_MINUS; "!": return M_H_BANG; "=": return M_H_EQ;
            "<": return M_H_LT;    ">": return M_H_GT;   "&": return M_H_AMP;
            "|": return M_H_BAR;   ":": return M_H_COLON;
            default: return M_IDLE;
        endcase
    endfunction

    task automatic scan_idle(input logic [7:0] c);
        logic [6:0] k;
        scan_mode = M_IDLE;
        if (c == 8'd0) begin
            token_begin = text_offset;
            push_plain(K_EOF, 0);
            text_offset = 0; token_begin = 0; line_count = 1; column_count = 1;
            word_count = 0; run_len = 0;
        end else if (c == " " || c == 8'd13 || c == 8'd9) begin
            step_over();
        end else if (c == 8'd10) begin
            start_token();
            new_line();
            column_count = 1;
            push_plain(K_NEWLINE, 1);
        end else if (c == "/") begin
            start_token(); scan_mode = M_SLASH;
        end else if (c == "\"") begin
            start_token(); scan_mode = M_STRING;
        end else if (is_letter(c) || c == "_") begin
            start_token(); word_buf[0] = c; word_count = 1; scan_mode = M_IDENT;
        end else if (is_num(c)) begin
            start_token(); scan_mode = M_NUM_INT;
        end else begin
            k = single_op(c);
            start_token();
            if (k != K_NONE) push_plain(k, 1);
            else if (hold_mode(c) != M_IDLE) scan_mode = hold_mode(c);
            else push_error(E_UNEXPECTED);
        end
    endtask

    // Predicts the tokens caused by one accepted byte.
    task automatic predict_tokens(input logic [7:0] c);
        bit           again;
        logic [7:0]   second;
        logic [6:0]   pair_k, lone_k;
        again = 1'b0;
        step_tokens = 0;
        case (scan_mode)
            M_IDENT: begin
                if (is_letter(c) || is_num(c) || c == "_") begin
                    if (word_count < WORD_LIMIT) begin
                        word_buf[word_count] = c; word_count++;
                    end else word_count = WORD_LIMIT + 1;
                    grow_len(1); step_over();
                end else begin
                    push_plain(word_kind(), run_len); again = 1'b1;
                end
            end
            M_NUM_INT, M_NUM_FRAC: begin
                if (is_num(c)) begin
                    grow_len(1); step_over();
                end else if (c == "." && scan_mode == M_NUM_INT) begin
                    step_over(); scan_mode = M_NUM_DOT;
                end else begin
                    push_plain(K_NUMBER, run_len); again = 1'b1;
                end
            end
            M_NUM_DOT: begin
                if (is_num(c)) begin
                    grow_len(2); step_over(); scan_mode = M_NUM_FRAC;
                end else begin
                    push_token(K_NUMBER, 1'b0, token_begin, run_len,
                               int'(column_count) - 1 - int'(run_len));
                    push_token(K_DOT, 1'b0, (text_offset + 65535) % 65536, 1,
                               int'(column_count) - 1);
                    again = 1'b1;
                end
            end
            M_STRING: begin
                if (c == "\"") begin
                    grow_len(1); step_over(); push_plain(K_STRING, run_len);
                    scan_mode = M_IDLE;
                end else if (c == 8'd0) begin
                    push_error(E_UNTERMINATED); again = 1'b1;
                end else begin
                    if (c == 8'd10) begin new_line(); column_count = 0; end
                    grow_len(1); step_over();
                end
            end
            M_SLASH: begin
                if (c == "/") begin step_over(); scan_mode = M_LINE; end
                else if (c == "*") begin step_over(); scan_mode = M_BLOCK; end
                else begin push_plain(K_SLASH, 1); again = 1'b1; end
            end
            M_LINE: begin
                if (c == 8'd10 || c == 8'd0) again = 1'b1;
                else step_over();
            end
            M_BLOCK, M_BLOCK_STAR: begin
                if (c == 8'd0) again = 1'b1;
                else if (c == "/" && scan_mode == M_BLOCK_STAR) begin
                    step_over(); scan_mode = M_IDLE;
                end else if (c == "*") begin
                    step_over(); scan_mode = M_BLOCK_STAR;
                end else begin
                    if (c == 8'd10) begin new_line(); column_count = 0; end
                    step_over(); scan_mode = M_BLOCK;
                end
            end
            M_IDLE: again = 1'b1;
            default: begin
                case (scan_mode)
                    M_H_MINUS: begin second = ">"; pair_k = K_ARROW; lone_k = K_MINUS;  end
                    M_H_BANG:  begin second = "="; pair_k = K_NE;    lone_k = K_BANG;   end
                    M_H_EQ:    begin second = "="; pair_k = K_EQ;    lone_k = K_ASSIGN; end
                    M_H_LT:    begin second = "="; pair_k = K_LE;    lone_k = K_LT;     end
                    M_H_GT:    begin second = "="; pair_k = K_GE;    lone_k = K_GT;     end
                    M_H_AMP:   begin second = "&"; pair_k = K_AND;   lone_k = K_NONE;   end
                    M_H_BAR:   begin second = "|"; pair_k = K_OR;    lone_k = K_NONE;   end
                    default:   begin second = ":"; pair_k = K_SCOPE; lone_k = K_COLON;  end
                endcase
                if (c == second) begin
                    step_over(); run_len = 2; push_plain(pair_k, 2);
                    scan_mode = M_IDLE;
                end else begin
                    if (lone_k == K_NONE) push_error(E_UNEXPECTED);
                    else push_plain(lone_k, 1);
                    again = 1'b1;
                end
            end
        endcase
        if (again) scan_idle(c);
        if (step_tokens > 0) token_queue[token_queue.size() - 1].last = 1'b1;
    endtask

    // Sends one byte and records what it should produce. Called at a falling
    // edge; returns at the falling edge after the byte is taken.
    task automatic send_byte(input logic [7:0] c);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_tokens(c);
        byte_count++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Receiver readiness, redrawn every falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Compares each accepted token with the oldest prediction.
    always @(posedge i_clk) begin
        t_expected_token e;
        if (i_rst_n && o_valid && i_ready) begin
            token_count++;
            if (token_queue.size() == 0) begin
                $display("%0t: unexpected token kind %0d", $time, o_token_kind);
                error_count++;
            end else begin
                e = token_queue.pop_front();
                if (o_token_kind !== e.tok.kind || o_error_code !== e.tok.code
                    || o_start_offset !== e.tok.start || o_token_length !== e.tok.len
                    || o_line_number !== e.tok.line || o_column_number !== e.tok.col
                    || o_last_of_run !== e.last) begin
                    $display("%0t: expected k%0d c%0d s%0d n%0d l%0d col%0d last%0b",
                             $time, e.tok.kind, e.tok.code, e.tok.start, e.tok.len,
                             e.tok.line, e.tok.col, e.last);
                    $display("%0t: actual   k%0d c%0d s%0d n%0d l%0d col%0d last%0b",
                             $time, o_token_kind, o_error_code, o_start_offset,
                             o_token_length, o_line_number, o_column_number,
                             o_last_of_run);
                    error_count++;
                end
            end
        end
    end

    // Operators, comments and the held-byte cases.
    task automatic test_operators();
        send_text("(){}[],.;+*%@ - -> ! != = == < <= > >= && || & | : :: / ");
        send_text("a/b //c\n/* x\n**/\"s\ni\" 1.5 2. 3.x 7\n");
        send_byte(8'd0);
    endtask

    // Keywords, long words, odd bytes and end of text in open states.
    task automatic test_words();
        send_text("robot counterclockwise InputPulldown UART _ x9 ");
        send_text("counterclockwisex abcdefghijklmnopqrstuvwxyz\t\r");
        send_byte(8'd128); send_byte(8'd255); send_byte("#");
        send_text("\"open"); send_byte(8'd0);
        send_text("/* open"); send_byte(8'd0);
        send_text("12."); send_byte(8'd0);
        send_text("<"); send_byte(8'd0);
    endtask

    function automatic string random_piece();
        string kw[8] = '{"robot", "if", "else", "Hz", "UART", "let", "wait", "motor"};
        string ops[12] = '{"->", "==", "!=", "<=", ">=", "&&", "||", "::",
                           "(", ")", ";", "."};
        string s;
        int n;
        case ($urandom_range(11, 0))
            0, 1: s = kw[$urandom_range(7, 0)];
            2: begin
                n = $urandom_range(20, 1);
                s = "w";
                for (int i = 1; i < n; i++) s = {s, string'(8'("a" + $urandom_range(25, 0)))};
            end
            3: s = $sformatf("%0d", $urandom_range(9999, 0));
            4: s = $sformatf("%0d.%0d", $urandom_range(99, 0), $urandom_range(99, 0));
            5: s = ops[$urandom_range(11, 0)];
            6: s = "\"str ing\"";
            7: s = "// note\n";
            8: s = "/* a*b\n */";
            9: s = "\n";
            10: s = string'(8'($urandom_range(255, 1)));
            default: s = " ";
        endcase
        return s;
    endfunction

    // Random well-formed text with some noise bytes, then the eof.
    task automatic test_random(input int n_bytes);
        int   target;
        string s;
        target = byte_count + n_bytes;
        while (byte_count < target) begin
            s = random_piece();
            send_text(s);
            if ($urandom_range(3, 0) == 0) send_byte(" ");
            if ($urandom_range(40, 0) == 0) send_byte(8'd0);
        end
        send_byte(8'd0);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (token_queue.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0; i_rst_n = 1'b0; i_valid = 1'b0; i_ch = 8'd0; i_ready = 1'b0;
        error_count = 0; token_count = 0; byte_count = 0;
        scan_mode = M_IDLE; word_count = 0; text_offset = 0; token_begin = 0;
        line_count = 1; column_count = 1; run_len = 0;
        foreach (word_buf[i]) word_buf[i] = 8'd0;
        send_idle_pct = 16; recv_idle_pct = 75;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_operators();
        test_words();
        test_random(100);
        send_idle_pct = 75; recv_idle_pct = 16;
        test_random(100);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(100);
        wait_drained();
        $display("Sent %0d source bytes; checked %0d tokens over three idling phases.",
                 byte_count, token_count);
        if (error_count == 0 && token_queue.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit.
    initial begin
        #4000000;
        $display("Timeout with %0d tokens outstanding.", token_queue.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
